/* sv/cpps_pkg.sv */
// Shared constants, types and tables for the closed path position sampler.
package cpps_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int PT_W         = $clog2(MAX_POINTS);
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;

  localparam logic [30:0] LEN_MAX  = 31'h7FFF_FFFF;
  localparam logic [30:0] LOOP_MIN = 31'((64'd1 << FRAC_BITS) / 64'd10000);
  localparam logic [30:0] SEG_MIN  = 31'((64'd1 << FRAC_BITS) / 64'd1000000);
  localparam logic [63:0] TAN_MIN  = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

  localparam logic signed [34:0] PI_Q30   = 35'sd3373259426;
  localparam logic signed [18:0] HEAD_MAX = 19'sd205887;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT,
    OP_ATAN
  } alu_op_e;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_DIV,
    AS_SQRT,
    AS_NORM,
    AS_ROT
  } alu_st_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_DIF,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SQS,
    ST_SQW,
    ST_ACC,
    ST_MODW,
    ST_EMIT,
    ST_BS0,
    ST_BS1,
    ST_I1,
    ST_I2,
    ST_I3,
    ST_IM,
    ST_ID,
    ST_IW,
    ST_HX,
    ST_HZ,
    ST_HC,
    ST_HW,
    ST_OUT
  } st_e;

  // Arctangent of 2^-i in Q30, truncated.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

/* sv/cpps_mem.sv */
// Point store and running-length memories, one write and one registered read port each.
module cpps_mem
  import cpps_pkg::*;
(
  input  logic             clk_i,
  input  logic             pt_we_i,
  input  logic [PT_W-1:0]  pt_waddr_i,
  input  logic [31:0]      wx_i,
  input  logic [31:0]      wy_i,
  input  logic [31:0]      wz_i,
  input  logic [PT_W-1:0]  pt_raddr_i,
  output logic [31:0]      rx_o,
  output logic [31:0]      ry_o,
  output logic [31:0]      rz_o,
  input  logic             rl_we_i,
  input  logic [CNT_W-1:0] rl_waddr_i,
  input  logic [30:0]      rl_wdata_i,
  input  logic [CNT_W-1:0] rl_raddr_i,
  output logic [30:0]      rl_rdata_o
);

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_z [MAX_POINTS];
  logic [30:0] mem_rl [MAX_POINTS+1];

  always_ff @(posedge clk_i) begin
    if (pt_we_i) begin
      mem_x[pt_waddr_i] <= wx_i;
      mem_y[pt_waddr_i] <= wy_i;
      mem_z[pt_waddr_i] <= wz_i;
    end
    rx_o <= mem_x[pt_raddr_i];
    ry_o <= mem_y[pt_raddr_i];
    rz_o <= mem_z[pt_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (rl_we_i) begin
      mem_rl[rl_waddr_i] <= rl_wdata_i;
    end
    rl_rdata_o <= mem_rl[rl_raddr_i];
  end

endmodule

/* sv/cpps_alu.sv */
// Shared arithmetic unit: registered multiply, serial divide, serial root, serial CORDIC.
module cpps_alu
  import cpps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alu_req_t           req_i,
  input  logic [63:0]        opa_i,
  input  logic signed [33:0] opb_i,
  output alu_rsp_t           rsp_o,
  output logic [63:0]        mul_o,
  output logic [63:0]        quo_o,
  output logic [30:0]        rem_o,
  output logic [32:0]        root_o,
  output logic signed [18:0] hd_o
);

  localparam logic signed [36:0] NORM_LIM = 37'sd2147483648;

  alu_st_e st_q, st_d;
  logic [5:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic [63:0] mul_q, mul_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [30:0] div_q, div_d;
  logic [63:0] v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic signed [36:0] x_q, x_d, y_q, y_d;
  logic signed [34:0] z_q, z_d;
  logic signed [18:0] hd_q, hd_d;

  logic [64:0] prod;
  logic [32:0] dv_t;
  logic dv_ge;
  logic [63:0] sq_rb;
  logic sq_ge;
  logic signed [36:0] sh_x, sh_y, ax, ay;
  logic signed [34:0] az, atv, hround;
  logic norm_small;

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    mul_d  = mul_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    hd_d   = hd_q;

    prod  = 65'(opa_i[32:0]) * 65'(opb_i[31:0]);
    dv_t  = {rem_q[31:0], quo_q[63]};
    dv_ge = dv_t >= {2'b00, div_q};
    sq_rb = r_q + bit_q;
    sq_ge = v_q >= sq_rb;
    sh_x  = x_q >>> cnt_q[4:0];
    sh_y  = y_q >>> cnt_q[4:0];
    atv   = $signed({5'b0, atan_q30(cnt_q[4:0])});
    if (y_q > 37'sd0) begin
      ax = x_q + sh_y;
      ay = y_q - sh_x;
      az = z_q + atv;
    end else begin
      ax = x_q - sh_y;
      ay = y_q + sh_x;
      az = z_q - atv;
    end
    hround = (az + 35'sd8192) >>> 14;
    norm_small = (x_q < NORM_LIM) && (x_q > -NORM_LIM) &&
                 (y_q < NORM_LIM) && (y_q > -NORM_LIM);

    unique case (st_q)
      AS_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_MUL: mul_d = prod[63:0];
            OP_DIV: begin
              rem_d = '0;
              quo_d = opa_i;
              div_d = opb_i[30:0];
              cnt_d = '0;
              st_d  = AS_DIV;
            end
            OP_SQRT: begin
              v_d   = opa_i;
              r_d   = '0;
              bit_d = 64'd1 << 62;
              cnt_d = '0;
              st_d  = AS_SQRT;
            end
            OP_ATAN: begin
              if (opb_i < 34'sd0) begin
                z_d = (opa_i[33] == 1'b0) ? PI_Q30 : -PI_Q30;
                x_d = -37'(opb_i);
                y_d = -37'($signed(opa_i[33:0]));
              end else begin
                z_d = '0;
                x_d = 37'(opb_i);
                y_d = 37'($signed(opa_i[33:0]));
              end
              st_d = AS_NORM;
            end
            default: st_d = AS_IDLE;
          endcase
        end
      end
      AS_DIV: begin
        rem_d = dv_ge ? dv_t - {2'b00, div_q} : dv_t;
        quo_d = {quo_q[62:0], dv_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          done_d = 1'b1;
          st_d   = AS_IDLE;
        end
      end
      AS_SQRT: begin
        v_d   = sq_ge ? v_q - sq_rb : v_q;
        r_d   = sq_ge ? (r_q >> 1) + bit_q : r_q >> 1;
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          done_d = 1'b1;
          st_d   = AS_IDLE;
        end
      end
      AS_NORM: begin
        // double both until one of them reaches 2^31
        if (norm_small) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          cnt_d = '0;
          st_d  = AS_ROT;
        end
      end
      AS_ROT: begin
        x_d   = ax;
        y_d   = ay;
        z_d   = az;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
          if (hround > 35'(HEAD_MAX)) begin
            hd_d = HEAD_MAX;
          end else if (hround < -35'(HEAD_MAX)) begin
            hd_d = -HEAD_MAX;
          end else begin
            hd_d = hround[18:0];
          end
          done_d = 1'b1;
          st_d   = AS_IDLE;
        end
      end
      default: st_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AS_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    hd_q  <= hd_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.rem_nz = (rem_q != '0);
  assign mul_o  = mul_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[30:0];
  assign root_o = r_q[32:0];
  assign hd_o   = hd_q;

endmodule

/* sv/closed_path_position_sampler.sv */
// Top level: sequencer for loading a closed path, measuring it and sampling positions.
//
// A point beat without last_point_i leaves busy_o low. The last point measures every
// segment with one shared unit (three squares, a square root, memory reads), then a sample.
// A move beat runs a division for the remainder, then a sample. A sample runs a binary
// search, up to three divisions for interpolation and a normalization and CORDIC for yaw.
// Each result shows on the output ports for one cycle with valid_o high and is not held:
// the receiver must take it. Moves while a load is open, or while the loop is not longer
// than the minimum, give no result.
module closed_path_position_sampler
  import cpps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               last_point_i,
  input  logic signed [31:0] travel_distance_i,
  output logic               valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [18:0] heading_o,
  output logic [30:0]        distance_now_o
);

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  st_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [30:0] loop_q, loop_d, pos_q, pos_d;
  logic open_q, open_d;

  logic [CNT_W-1:0] idx_q, idx_d, first_q, first_d, count_q, count_d;
  logic [30:0] sum_q, sum_d, seg_q, seg_d, base_q, base_d, len_q, len_d, num_q, num_d;
  logic [63:0] acc_q, acc_d;
  logic [32:0] mx_q, mx_d, my_q, my_d, mz_q, mz_d;
  logic signed [31:0] ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic signed [32:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic signed [18:0] hd_q, hd_d;
  logic [1:0] axis_q, axis_d;
  logic sgn_q, sgn_d;

  logic pt_we, rl_we;
  logic [PT_W-1:0] pt_waddr, pt_raddr;
  logic [CNT_W-1:0] rl_waddr, rl_raddr;
  logic [30:0] rl_wdata, rl_rdata;
  logic signed [31:0] rx, ry, rz;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic [63:0] alu_opa, mul_p, quo;
  logic signed [33:0] alu_opb;
  logic [30:0] rem;
  logic [32:0] root;
  logic signed [18:0] alu_hd;

  logic accept;
  logic [CNT_W-1:0] cnt_eff, step, bs_k, i1, nxt;
  logic signed [33:0] msum;
  logic [31:0] rsum;
  logic signed [32:0] dsel;
  logic signed [31:0] asel;
  logic [33:0] qadj;
  logic signed [34:0] qval, pval;
  logic [32:0] hxm, hzm;
  logic [32:0] dmx, dmy, dmz;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  cpps_mem u_mem (
    .clk_i      (clk_i),
    .pt_we_i    (pt_we),
    .pt_waddr_i (pt_waddr),
    .wx_i       (point_x_i),
    .wy_i       (point_y_i),
    .wz_i       (point_z_i),
    .pt_raddr_i (pt_raddr),
    .rx_o       (rx),
    .ry_o       (ry),
    .rz_o       (rz),
    .rl_we_i    (rl_we),
    .rl_waddr_i (rl_waddr),
    .rl_wdata_i (rl_wdata),
    .rl_raddr_i (rl_raddr),
    .rl_rdata_o (rl_rdata)
  );

  cpps_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (alu_opa),
    .opb_i  (alu_opb),
    .rsp_o  (alu_rsp),
    .mul_o  (mul_p),
    .quo_o  (quo),
    .rem_o  (rem),
    .root_o (root),
    .hd_o   (alu_hd)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    loop_d  = loop_q;
    pos_d   = pos_q;
    open_d  = open_q;
    idx_d   = idx_q;
    first_d = first_q;
    count_d = count_q;
    sum_d   = sum_q;
    seg_d   = seg_q;
    base_d  = base_q;
    len_d   = len_q;
    num_d   = num_q;
    acc_d   = acc_q;
    mx_d    = mx_q;
    my_d    = my_q;
    mz_d    = mz_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    az_d    = az_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    dz_d    = dz_q;
    px_d    = px_q;
    py_d    = py_q;
    pz_d    = pz_q;
    hd_d    = hd_q;
    axis_d  = axis_q;
    sgn_d   = sgn_q;

    pt_we    = 1'b0;
    pt_waddr = '0;
    pt_raddr = '0;
    rl_we    = 1'b0;
    rl_waddr = '0;
    rl_wdata = '0;
    rl_raddr = '0;
    alu_req  = '{start: 1'b0, op: OP_MUL};
    alu_opa  = '0;
    alu_opb  = '0;

    cnt_eff = open_q ? cnt_q : '0;
    msum    = $signed({3'b000, pos_q}) + 34'(travel_distance_i);
    rsum    = {1'b0, sum_q} + {1'b0, seg_q};
    step    = count_q >> 1;
    bs_k    = first_q + step;
    nxt     = idx_q + CNT_W'(1);
    if (first_q > cnt_q) begin
      i1 = cnt_q;
    end else if (first_q == '0) begin
      i1 = CNT_W'(1);
    end else begin
      i1 = first_q;
    end
    dmx = mag33(33'(rx) - 33'(ax_q));
    dmy = mag33(33'(ry) - 33'(ay_q));
    dmz = mag33(33'(rz) - 33'(az_q));
    case (axis_q)
      2'd0: begin
        dsel = dx_q;
        asel = ax_q;
      end
      2'd1: begin
        dsel = dy_q;
        asel = ay_q;
      end
      default: begin
        dsel = dz_q;
        asel = az_q;
      end
    endcase
    // round the quotient magnitude up only for a negative step, so the result floors
    qadj = quo[33:0] + 34'(dsel[32] && alu_rsp.rem_nz);
    qval = dsel[32] ? -$signed({1'b0, qadj}) : $signed({1'b0, qadj});
    pval = 35'(asel) + qval;
    hxm  = mag33(dx_q);
    hzm  = mag33(dz_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            cnt_d  = cnt_eff;
            open_d = 1'b1;
            if (cnt_eff < CNT_W'(MAX_POINTS)) begin
              pt_we    = 1'b1;
              pt_waddr = cnt_eff[PT_W-1:0];
              cnt_d    = cnt_eff + CNT_W'(1);
            end
            if (last_point_i) begin
              open_d  = 1'b0;
              idx_d   = '0;
              sum_d   = '0;
              state_d = ST_RDA;
            end
          end else if (!open_q && loop_q > LOOP_MIN) begin
            sgn_d         = msum[33];
            alu_req.start = 1'b1;
            alu_req.op    = OP_DIV;
            alu_opa       = {30'b0, msum[33] ? 34'(-msum) : 34'(msum)};
            alu_opb       = {3'b000, loop_q};
            state_d       = ST_MODW;
          end
        end
      end
      ST_RDA: begin
        pt_raddr = idx_q[PT_W-1:0];
        if (idx_q == '0) begin
          rl_we    = 1'b1;
          rl_waddr = '0;
          rl_wdata = '0;
        end
        state_d = ST_RDB;
      end
      ST_RDB: begin
        ax_d     = rx;
        ay_d     = ry;
        az_d     = rz;
        pt_raddr = (nxt == cnt_q) ? '0 : nxt[PT_W-1:0];
        state_d  = ST_DIF;
      end
      ST_DIF: begin
        mx_d = dmx;
        my_d = dmy;
        mz_d = dmz;
        if (dmx[32:31] != 2'b00 || dmy[32:31] != 2'b00 || dmz[32:31] != 2'b00) begin
          seg_d   = LEN_MAX;
          state_d = ST_ACC;
        end else begin
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        alu_req.start = 1'b1;
        alu_opa       = {31'b0, mx_q};
        alu_opb       = {1'b0, mx_q};
        state_d       = ST_SQY;
      end
      ST_SQY: begin
        acc_d         = mul_p;
        alu_req.start = 1'b1;
        alu_opa       = {31'b0, my_q};
        alu_opb       = {1'b0, my_q};
        state_d       = ST_SQZ;
      end
      ST_SQZ: begin
        acc_d         = acc_q + mul_p;
        alu_req.start = 1'b1;
        alu_opa       = {31'b0, mz_q};
        alu_opb       = {1'b0, mz_q};
        state_d       = ST_SQS;
      end
      ST_SQS: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_SQRT;
        alu_opa       = acc_q + mul_p;
        state_d       = ST_SQW;
      end
      ST_SQW: begin
        if (alu_rsp.done) begin
          seg_d   = (root > 33'(LEN_MAX)) ? LEN_MAX : root[30:0];
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        rl_we    = 1'b1;
        rl_waddr = nxt;
        rl_wdata = rsum[31] ? LEN_MAX : rsum[30:0];
        sum_d    = rl_wdata;
        if (nxt == cnt_q) begin
          loop_d  = rl_wdata;
          pos_d   = rl_wdata >> 2;
          state_d = ST_EMIT;
        end else begin
          idx_d   = nxt;
          state_d = ST_RDA;
        end
      end
      ST_MODW: begin
        if (alu_rsp.done) begin
          pos_d   = (sgn_q && alu_rsp.rem_nz) ? loop_q - rem : rem;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cnt_q != '0 && loop_q > LOOP_MIN) begin
          first_d = '0;
          count_d = cnt_q + CNT_W'(1);
          state_d = ST_BS0;
        end else begin
          px_d    = '0;
          py_d    = '0;
          pz_d    = '0;
          hd_d    = '0;
          state_d = ST_OUT;
        end
      end
      ST_BS0: begin
        rl_raddr = bs_k;
        state_d  = (count_q == '0) ? ST_I1 : ST_BS1;
      end
      ST_BS1: begin
        // upper bound: skip past every sum not above the distance
        if (!(pos_q < rl_rdata)) begin
          first_d = bs_k + CNT_W'(1);
          count_d = count_q - step - CNT_W'(1);
        end else begin
          count_d = step;
        end
        state_d = ST_BS0;
      end
      ST_I1: begin
        idx_d    = i1;
        rl_raddr = i1 - CNT_W'(1);
        pt_raddr = rl_raddr[PT_W-1:0];
        state_d  = ST_I2;
      end
      ST_I2: begin
        base_d   = rl_rdata;
        ax_d     = rx;
        ay_d     = ry;
        az_d     = rz;
        rl_raddr = idx_q;
        pt_raddr = (idx_q == cnt_q) ? '0 : idx_q[PT_W-1:0];
        state_d  = ST_I3;
      end
      ST_I3: begin
        len_d   = rl_rdata - base_q;
        num_d   = pos_q - base_q;
        dx_d    = 33'(rx) - 33'(ax_q);
        dy_d    = 33'(ry) - 33'(ay_q);
        dz_d    = 33'(rz) - 33'(az_q);
        axis_d  = '0;
        state_d = ST_IM;
      end
      ST_IM: begin
        if (len_q > SEG_MIN && num_q != '0) begin
          alu_req.start = 1'b1;
          alu_opa       = {31'b0, mag33(dsel)};
          alu_opb       = {3'b000, num_q};
          state_d       = ST_ID;
        end else begin
          case (axis_q)
            2'd0:    px_d = asel;
            2'd1:    py_d = asel;
            default: pz_d = asel;
          endcase
          axis_d  = axis_q + 2'd1;
          state_d = (axis_q == 2'd2) ? ST_HX : ST_IM;
        end
      end
      ST_ID: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_opa       = mul_p;
        alu_opb       = {3'b000, len_q};
        state_d       = ST_IW;
      end
      ST_IW: begin
        if (alu_rsp.done) begin
          case (axis_q)
            2'd0:    px_d = pval[31:0];
            2'd1:    py_d = pval[31:0];
            default: pz_d = pval[31:0];
          endcase
          axis_d  = axis_q + 2'd1;
          state_d = (axis_q == 2'd2) ? ST_HX : ST_IM;
        end
      end
      ST_HX: begin
        if (dx_q == '0 && dz_q == '0) begin
          hd_d    = '0;
          state_d = ST_OUT;
        end else if (hxm[32:31] != 2'b00 || hzm[32:31] != 2'b00) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_ATAN;
          alu_opa       = 64'(dx_q);
          alu_opb       = 34'(dz_q);
          state_d       = ST_HW;
        end else begin
          alu_req.start = 1'b1;
          alu_opa       = {31'b0, hxm};
          alu_opb       = {1'b0, hxm};
          state_d       = ST_HZ;
        end
      end
      ST_HZ: begin
        acc_d         = mul_p;
        alu_req.start = 1'b1;
        alu_opa       = {31'b0, hzm};
        alu_opb       = {1'b0, hzm};
        state_d       = ST_HC;
      end
      ST_HC: begin
        if (acc_q + mul_p >= TAN_MIN) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_ATAN;
          alu_opa       = 64'(dx_q);
          alu_opb       = 34'(dz_q);
          state_d       = ST_HW;
        end else begin
          hd_d    = '0;
          state_d = ST_OUT;
        end
      end
      ST_HW: begin
        if (alu_rsp.done) begin
          hd_d    = alu_hd;
          state_d = ST_OUT;
        end
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      loop_q  <= '0;
      pos_q   <= '0;
      open_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      loop_q  <= loop_d;
      pos_q   <= pos_d;
      open_q  <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    first_q <= first_d;
    count_q <= count_d;
    sum_q   <= sum_d;
    seg_q   <= seg_d;
    base_q  <= base_d;
    len_q   <= len_d;
    num_q   <= num_d;
    acc_q   <= acc_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    mz_q    <= mz_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    az_q    <= az_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    dz_q    <= dz_d;
    px_q    <= px_d;
    py_q    <= py_d;
    pz_q    <= pz_d;
    hd_q    <= hd_d;
    axis_q  <= axis_d;
    sgn_q   <= sgn_d;
  end

  assign valid_o        = (state_q == ST_OUT);
  assign pos_x_o        = px_q;
  assign pos_y_o        = py_q;
  assign pos_z_o        = pz_q;
  assign heading_o      = hd_q;
  assign distance_now_o = pos_q;

endmodule

/* sv/cpps_checker.sv */
// Port-level checks for the sampler, bound to the top level.
module cpps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               mode_i,
  input logic               last_point_i,
  input logic               valid_o,
  input logic signed [18:0] heading_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result shown while idle");

  a_free_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o)
    else $error("block still busy after result");

  a_plain_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !mode_i && !last_point_i) |=> (!busy_o && !valid_o))
    else $error("plain point beat did not complete at once");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (heading_o <= 19'sd205887 && heading_o >= -19'sd205887))
    else $error("heading out of range");

endmodule

bind closed_path_position_sampler cpps_checker u_cpps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .mode_i       (mode_i),
  .last_point_i (last_point_i),
  .valid_o      (valid_o),
  .heading_o    (heading_o)
);

/* dv/closed_path_position_sampler_tb.sv */
// Testbench for the closed path position sampler: directed table plus random paths and moves.
module closed_path_position_sampler_tb;
  import cpps_pkg::*;

  typedef struct {
    logic               mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
    logic signed [31:0] delta;
  } beat_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [18:0] hd;
    logic [30:0]        dn;
  } sample_t;

  // Directed row: beat, whether a sample is typed in, and that sample.
  typedef struct {
    beat_t   b;
    logic    typed;
    sample_t s;
  } row_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MOVE = 1'b1;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam longint LIMIT_CYCLES = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               mode_i = 1'b0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] point_z_i = '0;
  logic               last_point_i = 1'b0;
  logic signed [31:0] travel_distance_i = '0;
  logic               valid_o;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic signed [31:0] pos_z_o;
  logic signed [18:0] heading_o;
  logic [30:0]        distance_now_o;

  closed_path_position_sampler u_dut (.*);

  always #6 clk_i = ~clk_i;

  // Path model state
  longint path_x[MAX_POINTS];
  longint path_y[MAX_POINTS];
  longint path_z[MAX_POINTS];
  longint arc_sum[MAX_POINTS + 1];
  int     n_points = 0;
  longint loop_len = 0;
  longint travel = 0;
  bit     loading = 0;

  sample_t pending_samples[$];
  row_t    rows[$];
  int      n_errors = 0;
  int      idle_pct = 0;

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic void queue_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(bit [63:0] v);
    bit [63:0] r = 0;
    bit [63:0] b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint edge_len(int a, int b);
    longint dx = absl(path_x[a] - path_x[b]);
    longint dy = absl(path_y[a] - path_y[b]);
    longint dz = absl(path_z[a] - path_z[b]);
    longint r;
    if (dx >= 64'h8000_0000 || dy >= 64'h8000_0000 || dz >= 64'h8000_0000)
      return longint'(LEN_MAX);
    r = root_floor(64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz));
    return r > longint'(LEN_MAX) ? longint'(LEN_MAX) : r;
  endfunction

  function automatic longint yaw_of(longint y, longint x);
    longint z = 0;
    longint nx, ny, h;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    while (absl(x) < 64'h8000_0000 && absl(y) < 64'h8000_0000) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(atan_q30(5'(i)));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(atan_q30(5'(i)));
      end
      x = nx;
      y = ny;
    end
    h = (z + (64'sd1 <<< 13)) >>> 14;
    if (h > longint'(HEAD_MAX)) h = HEAD_MAX;
    if (h < -longint'(HEAD_MAX)) h = -longint'(HEAD_MAX);
    return h;
  endfunction

  function automatic longint div_floor(longint a, longint b);
    longint q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic sample_t sample_here();
    sample_t s;
    longint px = 0, py = 0, pz = 0, hd = 0;
    longint seg0, slen, num, hx, hz;
    int lo, cnt, stp, k, i1, a, b;
    if (n_points > 0 && loop_len > longint'(LOOP_MIN)) begin
      lo = 0;
      cnt = n_points + 1;
      while (cnt > 0) begin
        stp = cnt / 2;
        k = lo + stp;
        if (!(travel < arc_sum[k])) begin
          lo = k + 1;
          cnt -= stp + 1;
        end else begin
          cnt = stp;
        end
      end
      i1 = lo > n_points ? n_points : lo;
      if (i1 < 1) i1 = 1;
      a = i1 - 1;
      b = i1 % n_points;
      seg0 = arc_sum[a];
      slen = arc_sum[i1] - seg0;
      num = travel - seg0;
      px = path_x[a];
      py = path_y[a];
      pz = path_z[a];
      if (slen > longint'(SEG_MIN) && num > 0) begin
        px += div_floor((path_x[b] - path_x[a]) * num, slen);
        py += div_floor((path_y[b] - path_y[a]) * num, slen);
        pz += div_floor((path_z[b] - path_z[a]) * num, slen);
      end
      hx = path_x[b] - path_x[a];
      hz = path_z[b] - path_z[a];
      if (!(hx == 0 && hz == 0) &&
          (absl(hx) >= 64'h8000_0000 || absl(hz) >= 64'h8000_0000 ||
           64'(absl(hx) * absl(hx)) + 64'(absl(hz) * absl(hz)) >= TAN_MIN))
        hd = yaw_of(hx, hz);
    end
    s.px = px[31:0];
    s.py = py[31:0];
    s.pz = pz[31:0];
    s.hd = hd[18:0];
    s.dn = travel[30:0];
    return s;
  endfunction

  // Advance the path model by one beat; returns 1 when a sample is due.
  function automatic bit path_step(beat_t bt, output sample_t s);
    longint acc, r;
    if (bt.mode == MODE_LOAD) begin
      if (!loading) begin
        n_points = 0;
        loading = 1;
      end
      if (n_points < MAX_POINTS) begin
        path_x[n_points] = longint'(bt.x);
        path_y[n_points] = longint'(bt.y);
        path_z[n_points] = longint'(bt.z);
        n_points++;
      end
      if (!bt.last) return 0;
      loading = 0;
      arc_sum[0] = 0;
      for (int i = 0; i < n_points; i++) begin
        acc = arc_sum[i] + edge_len(i, (i + 1) % n_points);
        arc_sum[i + 1] = acc > longint'(LEN_MAX) ? longint'(LEN_MAX) : acc;
      end
      loop_len = arc_sum[n_points];
      travel = loop_len >> 2;
      s = sample_here();
      return 1;
    end
    if (loading || loop_len <= longint'(LOOP_MIN)) return 0;
    r = (travel + longint'(bt.delta)) % loop_len;
    if (r < 0) r += loop_len;
    travel = r;
    s = sample_here();
    return 1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Present one beat, hold it until busy_o is seen low, then log what it should produce.
  task automatic send_beat(beat_t bt, bit typed, sample_t typed_s);
    sample_t s;
    bit due;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= bt.mode;
    point_x_i <= bt.x;
    point_y_i <= bt.y;
    point_z_i <= bt.z;
    last_point_i <= bt.last;
    travel_distance_i <= bt.delta;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    due = path_step(bt, s);
    if (due) queue_sample(typed ? typed_s : s);
  endtask

  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && valid_o) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample with none pending");
      end else begin
        e = pending_samples.pop_front();
        if (pos_x_o !== e.px) report_mismatch($sformatf("pos_x %h exp %h", pos_x_o, e.px));
        if (pos_y_o !== e.py) report_mismatch($sformatf("pos_y %h exp %h", pos_y_o, e.py));
        if (pos_z_o !== e.pz) report_mismatch($sformatf("pos_z %h exp %h", pos_z_o, e.pz));
        if (heading_o !== e.hd)
          report_mismatch($sformatf("heading %h exp %h", heading_o, e.hd));
        if (distance_now_o !== e.dn)
          report_mismatch($sformatf("distance_now %h exp %h", distance_now_o, e.dn));
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    int pick = $urandom_range(99);
    if (pick < 65) return $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
    if (pick < 85) return $signed(32'($urandom_range(0, 32'h1000_0000))) - 32'sh0800_0000;
    return $signed($urandom());
  endfunction

  function automatic logic signed [31:0] rand_dist();
    int pick = $urandom_range(99);
    if (pick < 70) return $signed(32'($urandom_range(0, 32'h0080_0000))) - 32'sh0040_0000;
    return $signed($urandom());
  endfunction

  task automatic send_random(logic mode, logic last);
    beat_t bt;
    sample_t none;
    bt.mode = mode;
    bt.x = rand_coord();
    bt.y = rand_coord();
    bt.z = rand_coord();
    bt.last = last;
    bt.delta = rand_dist();
    send_beat(bt, 1'b0, none);
  endtask

  initial begin
    sample_t zs;
    int sent;
    int npts;
    zs = '{px: '0, py: '0, pz: '0, hd: '0, dn: '0};
    // move before any load: ignored
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, ONE}, 0, zs});
    // single point: loop is empty, sample is all zero
    add_row('{'{MODE_LOAD, ONE, ONE, ONE, 1, 0}, 1, zs});
    // two coincident points: zero-length loop
    add_row('{'{MODE_LOAD, 5, 7, 9, 0, 0}, 0, zs});
    add_row('{'{MODE_LOAD, 5, 7, 9, 1, 0}, 1, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, ONE}, 0, zs});
    // unit square in x-z: start a quarter round at corner (1,0,0), facing +z
    add_row('{'{MODE_LOAD, 0, 0, 0, 0, 0}, 0, zs});
    add_row('{'{MODE_LOAD, ONE, 0, 0, 0, 0}, 0, zs});
    add_row('{'{MODE_LOAD, ONE, 0, ONE, 0, 0}, 0, zs});
    add_row('{'{MODE_LOAD, 0, 0, ONE, 1, 0},
              1, '{px: ONE, py: '0, pz: '0, hd: '0, dn: 31'h1_0000}});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, 32'sh0000_8000}, 0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, -32'sh0000_C000}, 0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, 32'sh7FFF_FFFF}, 0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, 32'sh8000_0000}, 0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, 0}, 0, zs});
    // extreme coordinates, move while the load is open
    add_row('{'{MODE_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0},
              0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, ONE}, 0, zs});
    add_row('{'{MODE_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0},
              0, zs});
    add_row('{'{MODE_LOAD, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 1, 0}, 0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, 32'sh4000_0000}, 0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, -32'sh1234_5678}, 0, zs});
    // heading toward -z and -x: segment of a tiny triangle
    add_row('{'{MODE_LOAD, 0, 0, ONE, 0, 0}, 0, zs});
    add_row('{'{MODE_LOAD, -ONE, ONE, 0, 0, 0}, 0, zs});
    add_row('{'{MODE_LOAD, 0, 0, -ONE, 1, 0}, 0, zs});
    add_row('{'{MODE_MOVE, 0, 0, 0, 0, -ONE}, 0, zs});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 26;
    foreach (rows[i]) send_beat(rows[i].b, rows[i].typed, rows[i].s);

    sent = 0;
    while (sent < 1700) begin
      if (sent > 1133) idle_pct = 0;
      else if (sent > 566) idle_pct = 63;
      // mostly small paths; a few overflow the point store
      npts = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int p = 0; p < npts; p++) begin
        if (p > 0 && $urandom_range(99) < 5) begin
          send_random(MODE_MOVE, 1'($urandom_range(1)));
          sent++;
        end
        send_random(MODE_LOAD, p == npts - 1);
      end
      sent += npts;
      repeat ($urandom_range(1, 8)) begin
        send_random(MODE_MOVE, 1'($urandom_range(1)));
        sent++;
      end
    end
    start_i <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (n_errors == 0 && pending_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("simulation failed");
    $finish;
  end

endmodule
